// File: hw/rtl/seps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seps_pkg
// Shared constants, codes and helpers of the shape emission point sampler.
// ----------------------------------------------------------------------------
package seps_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // sin/cos series: terms and pipeline depth of one sin/cos unit
    localparam int SERIES_TERMS = 8;
    localparam int SC_LAT       = 3 * SERIES_TERMS + 4;

    localparam logic [31:0] PI_Q30  = 32'hC90F_DAA2;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // shape codes
    localparam logic [3:0] SHAPE_SPHERE   = 4'd0;
    localparam logic [3:0] SHAPE_HEMI     = 4'd1;
    localparam logic [3:0] SHAPE_CONE     = 4'd2;
    localparam logic [3:0] SHAPE_BOX      = 4'd3;
    localparam logic [3:0] SHAPE_CIRCLE   = 4'd4;
    localparam logic [3:0] SHAPE_EDGE     = 4'd5;
    localparam logic [3:0] SHAPE_CYLINDER = 4'd6;
    localparam logic [3:0] SHAPE_TORUS    = 4'd7;

    // emit_from codes
    localparam logic [1:0] EMIT_VOLUME = 2'd0;
    localparam logic [1:0] EMIT_SHELL  = 2'd1;
    localparam logic [1:0] EMIT_EDGE   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_SHAPE_TYPE  = 3'd0;
    localparam logic [2:0] CFG_EMIT_FROM   = 3'd1;
    localparam logic [2:0] CFG_RADIUS      = 3'd2;
    localparam logic [2:0] CFG_SWEEP_ANGLE = 3'd3;
    localparam logic [2:0] CFG_LENGTH      = 3'd4;
    localparam logic [2:0] CFG_TORUS_MAJOR = 3'd5;
    localparam logic [2:0] CFG_BOX_SIZE    = 3'd6;

    localparam int BOX_FACES = 6;

    localparam logic signed [31:0] OUT_MAX = 32'sd67108863;
    localparam logic signed [31:0] OUT_MIN = -32'sd67108864;

    typedef struct packed {
        logic signed [26:0] z;
        logic signed [26:0] y;
        logic signed [26:0] x;
    } t_xyz;

    // series divisors for term k
    function automatic int sin_den(input int k);
        return (2 * k) * (2 * k + 1);
    endfunction

    function automatic int cos_den(input int k);
        return (2 * k - 1) * (2 * k);
    endfunction

    function automatic logic signed [26:0] sat_out(input logic signed [31:0] v);
        logic signed [31:0] t;
        t = v;
        if (t > OUT_MAX) t = OUT_MAX;
        if (t < OUT_MIN) t = OUT_MIN;
        return t[26:0];
    endfunction

endpackage

// File: hw/rtl/shape_emission_point_sampler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_emission_point_sampler_core
// Turns three random fractions per word into a local emission offset on or
// inside the configured primitive shape, saturated signed Q10.16.
// ----------------------------------------------------------------------------
// One word enters and one result leaves per cycle unless the output stalls,
// which holds the whole pipeline; the sin/cos units (eight series terms at
// three stages each) set the depth. The user must write registers on the
// config channel only while no word is in flight; the block doesn't enforce it.
module shape_emission_point_sampler_core #(
    parameter int FRAC_BITS = seps_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // rand_a, rand_b, rand_c
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // offset_x, offset_y, offset_z, zero pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    localparam int LAT    = seps_pkg::SC_LAT;
    localparam int NST    = LAT + 5;
    localparam int RD_DLY = LAT - FRAC_BITS;
    localparam int SW     = FRAC_BITS + 2;
    localparam int PAW    = SW + 25;
    localparam int PBW    = SW + 28;
    localparam logic signed [PAW-1:0] HALF_A = PAW'(1) << (FRAC_BITS - 1);
    localparam logic signed [PBW-1:0] HALF_B = PBW'(1) << (FRAC_BITS - 1);
    localparam logic [FRAC_BITS+23:0] HALF_R = (FRAC_BITS+24)'(1) << (FRAC_BITS - 1);

    localparam logic [2:0] FACE_XP = 3'd0;
    localparam logic [2:0] FACE_XN = 3'd1;
    localparam logic [2:0] FACE_YP = 3'd2;
    localparam logic [2:0] FACE_YN = 3'd3;
    localparam logic [2:0] FACE_ZP = 3'd4;

    // configuration
    logic [3:0]  r_shape;
    logic [1:0]  r_emit;
    logic [23:0] r_radius;
    logic [16:0] r_sweep;
    logic [23:0] r_length;
    logic [23:0] r_major;
    logic [47:0] r_box;

    logic        en;
    logic [NST-1:0] r_vld;

    logic [15:0] r_a, r_b, r_c;

    // stage 1
    logic [31:0] r_ph1, r_ph2;
    logic [15:0] r_su;
    logic [23:0] r_draw;
    seps_pkg::t_xyz r_dir;
    logic [31:0] n_asw, n_ph1, n_ph2;
    logic [15:0] n_du;
    logic [23:0] n_dx, n_scaled, n_draw;
    logic [2:0]  n_face;
    seps_pkg::t_xyz n_dir;
    logic signed [15:0] ca, cb, cc;
    logic [15:0] bx, by, bz;

    logic signed [SW-1:0] s1, c1, s2, c2;
    logic [FRAC_BITS-1:0] sq_root;

    logic [23:0] r_rd    [FRAC_BITS];
    logic [23:0] r_rad_d [RD_DLY];
    logic [23:0] n_rad;
    seps_pkg::t_xyz r_dir_d [LAT+2];

    // M1..M3
    logic signed [27:0] r_ma, r_mb, n_ma, n_mb;
    logic signed [SW-1:0] r_s2d, r_c2d;
    logic signed [31:0] r_px, r_pz, r_y2;
    logic signed [PAW-1:0] pa, pb;
    logic signed [PBW-1:0] qx, qz;
    logic signed [24:0] r_in;
    logic [23:0] r_last;
    logic        trig, y_from_mb;
    seps_pkg::t_xyz n_out, r_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape  <= seps_pkg::SHAPE_SPHERE;
            r_emit   <= seps_pkg::EMIT_VOLUME;
            r_radius <= 24'd65536;
            r_sweep  <= 17'd65536;
            r_length <= 24'd65536;
            r_major  <= 24'd65536;
            r_box    <= 48'd1099528405248;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                seps_pkg::CFG_SHAPE_TYPE:  r_shape  <= i_cfg_data[3:0];
                seps_pkg::CFG_EMIT_FROM:   r_emit   <= i_cfg_data[1:0];
                seps_pkg::CFG_RADIUS:      r_radius <= i_cfg_data[23:0];
                seps_pkg::CFG_SWEEP_ANGLE: r_sweep  <= i_cfg_data[16:0];
                seps_pkg::CFG_LENGTH:      r_length <= i_cfg_data[23:0];
                seps_pkg::CFG_TORUS_MAJOR: r_major  <= i_cfg_data[23:0];
                seps_pkg::CFG_BOX_SIZE:    r_box    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline advances together
    assign en            = !r_vld[NST-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[NST-1];
    assign m_axis_tdata  = {7'd0, r_out.z, r_out.y, r_out.x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= s_axis_tdata[15:0];
            r_b <= s_axis_tdata[31:16];
            r_c <= s_axis_tdata[47:32];
        end
    end

    // stage 1: phases, drawn radius, shapes without trig
    always_comb begin
        bx = r_box[15:0];
        by = r_box[31:16];
        bz = r_box[47:32];
        ca = $signed({~r_a[15], r_a[14:0]});
        cb = $signed({~r_b[15], r_b[14:0]});
        cc = $signed({~r_c[15], r_c[14:0]});

        n_asw    = 32'(33'(r_a) * 33'(r_sweep));
        n_du     = (r_shape == seps_pkg::SHAPE_CIRCLE) ? r_b : r_c;
        n_dx     = (r_shape == seps_pkg::SHAPE_CONE) ? r_length : r_radius;
        n_scaled = 24'((40'(n_du) * 40'(n_dx)) >> 16);
        n_face   = 3'((19'(r_a) * 19'(seps_pkg::BOX_FACES)) >> 16);

        n_ph1  = '0;
        n_ph2  = '0;
        n_draw = r_radius;
        n_dir  = '0;
        case (r_shape)
            seps_pkg::SHAPE_SPHERE, seps_pkg::SHAPE_HEMI: begin
                n_ph1  = (r_shape == seps_pkg::SHAPE_SPHERE) ? {1'b0, r_b, 15'd0}
                                                             : {2'b0, r_b, 14'd0};
                n_ph2  = {r_a, 16'd0};
                n_draw = (r_emit == seps_pkg::EMIT_SHELL) ? r_radius : n_scaled;
            end
            seps_pkg::SHAPE_CONE: begin
                n_ph1  = n_asw;
                n_ph2  = {r_b, 16'd0};
                n_draw = n_scaled;
            end
            seps_pkg::SHAPE_BOX: begin
                if (r_emit == seps_pkg::EMIT_VOLUME) begin
                    n_dir.x = 27'((34'(ca) * 34'($signed({1'b0, bx}))) >>> 8);
                    n_dir.y = 27'((34'(cb) * 34'($signed({1'b0, by}))) >>> 8);
                    n_dir.z = 27'((34'(cc) * 34'($signed({1'b0, bz}))) >>> 8);
                end else begin
                    case (n_face)
                        FACE_XP: n_dir.x = $signed({4'd0, bx, 7'd0});
                        FACE_XN: n_dir.x = -$signed({4'd0, bx, 7'd0});
                        FACE_YP: n_dir.y = $signed({4'd0, by, 7'd0});
                        FACE_YN: n_dir.y = -$signed({4'd0, by, 7'd0});
                        FACE_ZP: n_dir.z = $signed({4'd0, bz, 7'd0});
                        default: n_dir.z = -$signed({4'd0, bz, 7'd0});
                    endcase
                end
            end
            seps_pkg::SHAPE_CIRCLE: begin
                n_ph2  = n_asw;
                n_draw = (r_emit == seps_pkg::EMIT_EDGE) ? r_radius : n_scaled;
            end
            seps_pkg::SHAPE_EDGE: begin
                n_dir.x = 27'(ca);
            end
            seps_pkg::SHAPE_CYLINDER: begin
                n_ph2   = {r_a, 16'd0};
                n_dir.y = 27'((42'(cc) * 42'($signed({1'b0, r_length}))) >>> 16);
            end
            seps_pkg::SHAPE_TORUS: begin
                n_ph1 = {r_b, 16'd0};
                n_ph2 = {r_a, 16'd0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ph1  <= n_ph1;
            r_ph2  <= n_ph2;
            r_su   <= (r_shape == seps_pkg::SHAPE_CYLINDER) ? r_b : r_c;
            r_draw <= n_draw;
            r_dir  <= n_dir;
        end
    end

    seps_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc1 (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_phase (r_ph1),
        .o_sin   (s1),
        .o_cos   (c1)
    );

    seps_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc2 (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_phase (r_ph2),
        .o_sin   (s2),
        .o_cos   (c2)
    );

    seps_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_u    (r_su),
        .o_root (sq_root)
    );

    // radius: sqrt-distributed for cylinder and torus volume
    always_comb begin
        if ((r_shape == seps_pkg::SHAPE_CYLINDER || r_shape == seps_pkg::SHAPE_TORUS) &&
            r_emit == seps_pkg::EMIT_VOLUME) begin
            n_rad = 24'(((FRAC_BITS+24)'(sq_root) * (FRAC_BITS+24)'(r_radius) + HALF_R)
                         >> FRAC_BITS);
        end else begin
            n_rad = r_rd[FRAC_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd[0]    <= r_draw;
            r_rad_d[0] <= n_rad;
            r_dir_d[0] <= r_dir;
            for (int i = 1; i < FRAC_BITS; i++) r_rd[i] <= r_rd[i-1];
            for (int i = 1; i < RD_DLY; i++) r_rad_d[i] <= r_rad_d[i-1];
            for (int i = 1; i < LAT + 2; i++) r_dir_d[i] <= r_dir_d[i-1];
        end
    end

    // M1: radius times first angle; circle and cylinder pass the radius
    always_comb begin
        r_last = r_rad_d[RD_DLY-1];
        r_in   = $signed({1'b0, r_last});
        pa = (PAW'(r_in) * PAW'((r_shape == seps_pkg::SHAPE_TORUS) ? c1 : s1) + HALF_A)
             >>> FRAC_BITS;
        pb = (PAW'(r_in) * PAW'((r_shape == seps_pkg::SHAPE_TORUS) ? s1 : c1) + HALF_A)
             >>> FRAC_BITS;
        n_ma = '0;
        n_mb = '0;
        case (r_shape)
            seps_pkg::SHAPE_SPHERE, seps_pkg::SHAPE_HEMI, seps_pkg::SHAPE_CONE: begin
                n_ma = 28'(pa);
                n_mb = 28'(pb);
            end
            seps_pkg::SHAPE_TORUS: begin
                n_ma = 28'(pa) + $signed({4'd0, r_major});
                n_mb = 28'(pb);
            end
            seps_pkg::SHAPE_CIRCLE, seps_pkg::SHAPE_CYLINDER: begin
                n_ma = 28'(r_in);
            end
            default: ;
        endcase
    end

    // M2: second angle
    always_comb begin
        qx = (PBW'(r_ma) * PBW'(r_c2d) + HALF_B) >>> FRAC_BITS;
        qz = (PBW'(r_ma) * PBW'(r_s2d) + HALF_B) >>> FRAC_BITS;
    end

    // M3: pick the source per shape and saturate
    always_comb begin
        trig = (r_shape == seps_pkg::SHAPE_SPHERE) || (r_shape == seps_pkg::SHAPE_HEMI) ||
               (r_shape == seps_pkg::SHAPE_CONE) || (r_shape == seps_pkg::SHAPE_CIRCLE) ||
               (r_shape == seps_pkg::SHAPE_CYLINDER) || (r_shape == seps_pkg::SHAPE_TORUS);
        y_from_mb = (r_shape == seps_pkg::SHAPE_SPHERE) || (r_shape == seps_pkg::SHAPE_HEMI) ||
                    (r_shape == seps_pkg::SHAPE_CONE) || (r_shape == seps_pkg::SHAPE_TORUS);
        n_out.x = trig ? seps_pkg::sat_out(r_px) : r_dir_d[LAT+1].x;
        n_out.z = trig ? seps_pkg::sat_out(r_pz) : r_dir_d[LAT+1].z;
        n_out.y = y_from_mb ? seps_pkg::sat_out(r_y2) : r_dir_d[LAT+1].y;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ma  <= n_ma;
            r_mb  <= n_mb;
            r_s2d <= s2;
            r_c2d <= c2;
            r_px  <= 32'(qx);
            r_pz  <= 32'(qz);
            r_y2  <= 32'(r_mb);
            r_out <= n_out;
        end
    end

endmodule

// File: hw/rtl/seps_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seps_sincos
// Pipelined sine/cosine of a 32-bit phase: quarter-wave series in Q30,
// rounded to FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module seps_sincos #(
    parameter int FRAC_BITS = seps_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [31:0]                 i_phase,
    output logic signed [FRAC_BITS+1:0] o_sin,
    output logic signed [FRAC_BITS+1:0] o_cos
);

    localparam int NT = seps_pkg::SERIES_TERMS;
    localparam int NS = 3 * NT;
    localparam logic [31:0] ONE32 = {1'b0, seps_pkg::Q30_ONE};
    localparam logic [31:0] ROUND = 32'(1) << (29 - FRAC_BITS);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic [1:0]  r_q1, r_q2;
    logic [30:0] r_x1, r_x2;
    logic [31:0] r_sq2;

    // x, x^2 and quadrant travel beside the series terms
    logic [30:0] r_cx  [NS];
    logic [31:0] r_csq [NS-3];
    logic [1:0]  r_cq  [NS];

    logic [31:0] r_pa_s [NT];
    logic [31:0] r_pa_c [NT];
    logic [31:0] r_pb_s [NT];
    logic [31:0] r_pb_c [NT];
    logic [31:0] r_q0_s [NT];
    logic [31:0] r_q0_c [NT];
    logic [30:0] r_t_s  [NT];
    logic [30:0] r_t_c  [NT];

    logic [30:0] r_vs;
    logic [30:0] r_hc;
    logic [1:0]  r_qf;

    logic signed [FRAC_BITS+1:0] n_sv, n_cv;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1  <= i_phase[31:30];
            r_x1  <= 31'((62'(i_phase[29:0]) * 62'(seps_pkg::PI_Q30)) >> 31);
            r_q2  <= r_q1;
            r_x2  <= r_x1;
            r_sq2 <= 32'((62'(r_x1) * 62'(r_x1)) >> 30);
            r_cx[0]  <= r_x2;
            r_cq[0]  <= r_q2;
            r_csq[0] <= r_sq2;
            for (int i = 1; i < NS; i++) begin
                r_cx[i] <= r_cx[i-1];
                r_cq[i] <= r_cq[i-1];
            end
            for (int i = 1; i < NS - 3; i++) begin
                r_csq[i] <= r_csq[i-1];
            end
        end
    end

    // one term per three stages: t*x^2, reciprocal multiply, correct and subtract
    for (genvar j = 0; j < NT; j++) begin : g_term
        localparam int K  = NT - j;
        localparam int DS = seps_pkg::sin_den(K);
        localparam int DC = seps_pkg::cos_den(K);
        localparam logic [31:0] MS = 32'((64'd1 << 32) / DS);
        localparam logic [31:0] MC = 32'((64'd1 << 32) / DC);

        logic [30:0] t_in_s, t_in_c;
        logic [31:0] sq_in;
        logic [31:0] rem_s, rem_c, d_s, d_c;

        if (j == 0) begin : g_first
            assign t_in_s = seps_pkg::Q30_ONE;
            assign t_in_c = seps_pkg::Q30_ONE;
            assign sq_in  = r_sq2;
        end else begin : g_next
            assign t_in_s = r_t_s[j-1];
            assign t_in_c = r_t_c[j-1];
            assign sq_in  = r_csq[3*j-1];
        end

        always_comb begin
            rem_s = r_pb_s[j] - 32'(r_q0_s[j] * 32'(DS));
            rem_c = r_pb_c[j] - 32'(r_q0_c[j] * 32'(DC));
            d_s   = r_q0_s[j] + ((rem_s >= 32'(DS)) ? 32'd1 : 32'd0);
            d_c   = r_q0_c[j] + ((rem_c >= 32'(DC)) ? 32'd1 : 32'd0);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pa_s[j] <= 32'((63'(t_in_s) * 63'(sq_in)) >> 30);
                r_pa_c[j] <= 32'((63'(t_in_c) * 63'(sq_in)) >> 30);
                r_pb_s[j] <= r_pa_s[j];
                r_pb_c[j] <= r_pa_c[j];
                r_q0_s[j] <= 32'((64'(r_pa_s[j]) * 64'(MS)) >> 32);
                r_q0_c[j] <= 32'((64'(r_pa_c[j]) * 64'(MC)) >> 32);
                r_t_s[j]  <= (d_s > ONE32) ? '0 : 31'(ONE32 - d_s);
                r_t_c[j]  <= (d_c > ONE32) ? '0 : 31'(ONE32 - d_c);
            end
        end
    end

    always_comb begin
        n_sv = (FRAC_BITS+2)'(({1'b0, r_vs} + ROUND) >> (30 - FRAC_BITS));
        n_cv = (FRAC_BITS+2)'(({1'b0, r_hc} + ROUND) >> (30 - FRAC_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vs <= 31'((62'(r_cx[NS-1]) * 62'(r_t_s[NT-1])) >> 30);
            r_hc <= r_t_c[NT-1];
            r_qf <= r_cq[NS-1];
            case (r_qf)
                QUAD_0: begin
                    o_sin <= n_sv;
                    o_cos <= n_cv;
                end
                QUAD_1: begin
                    o_sin <= n_cv;
                    o_cos <= -n_sv;
                end
                QUAD_2: begin
                    o_sin <= -n_sv;
                    o_cos <= -n_cv;
                end
                default: begin
                    o_sin <= -n_cv;
                    o_cos <= n_sv;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/seps_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seps_sqrt
// Pipelined floor square root of a 16-bit fraction scaled to 2*FRAC_BITS
// bits; one root bit per stage.
// ----------------------------------------------------------------------------
module seps_sqrt #(
    parameter int FRAC_BITS = seps_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [15:0]          i_u,
    output logic [FRAC_BITS-1:0] o_root
);

    localparam int RW = 2 * FRAC_BITS;
    localparam int EW = FRAC_BITS + 2;

    logic [RW-1:0]        r_v    [FRAC_BITS];
    logic [EW-1:0]        r_rem  [FRAC_BITS];
    logic [FRAC_BITS-1:0] r_root [FRAC_BITS];

    for (genvar i = 0; i < FRAC_BITS; i++) begin : g_bit
        logic [RW-1:0]        v_in;
        logic [EW-1:0]        rem_in;
        logic [FRAC_BITS-1:0] root_in;
        logic [EW+1:0]        tmp, trial;
        logic                 take;

        if (i == 0) begin : g_first
            assign v_in    = RW'(i_u) << (RW - 16);
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign v_in    = r_v[i-1];
            assign rem_in  = r_rem[i-1];
            assign root_in = r_root[i-1];
        end

        always_comb begin
            tmp   = {rem_in, v_in[RW-1-2*i -: 2]};
            trial = (EW+2)'({root_in, 2'b01});
            take  = (tmp >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[i]    <= v_in;
                r_rem[i]  <= take ? EW'(tmp - trial) : EW'(tmp);
                r_root[i] <= {root_in[FRAC_BITS-2:0], take};
            end
        end
    end

    assign o_root = r_root[FRAC_BITS-1];

endmodule

// File: verif/shape_emission_point_sampler_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_emission_point_sampler_core_tb
// Drives random fractions through every shape and emission mode, predicts
// each offset with a bit-exact fixed-point sampler model, and checks every
// output word in order under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module shape_emission_point_sampler_core_tb;

    localparam longint unsigned Q30 = 64'h4000_0000;
    localparam longint unsigned PI30 = 64'hC90F_DAA2;
    localparam int LATENCY = seps_pkg::SC_LAT + 5;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // rand_a, rand_b, rand_c
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;        // offset_x, offset_y, offset_z, zero pad
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [47:0] i_cfg_data = '0;

    // mirrored register file
    logic [3:0]  shape_q;
    logic [1:0]  emit_q;
    logic [23:0] radius_q, length_q, major_q;
    logic [16:0] sweep_q;
    logic [47:0] box_q;

    seps_pkg::t_xyz offset_queue[$];
    int   fail_cnt = 0;
    int   burst_left = 0;
    int   stall_mode = 0;

    shape_emission_point_sampler_core u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- sampler model ----------------
    function automatic longint unsigned series_q30(longint unsigned sq, bit odd);
        longint unsigned t, d, den;
        t = Q30;
        for (int k = seps_pkg::SERIES_TERMS; k >= 1; k--) begin
            den = odd ? longint'(seps_pkg::sin_den(k)) : longint'(seps_pkg::cos_den(k));
            d = ((t * sq) >> 30) / den;
            t = (d > Q30) ? 0 : Q30 - d;
        end
        return t;
    endfunction

    function automatic void phase_sin_cos(input logic [31:0] ph, output longint s,
                                          output longint c);
        longint unsigned r, x, sq;
        longint sv, cv;
        r = ph[29:0];
        x = (r * PI30) >> 31;
        sq = (x * x) >> 30;
        sv = longint'((((x * series_q30(sq, 1'b1)) >> 30) + 64'd8192) >> 14);
        cv = longint'((series_q30(sq, 1'b0) + 64'd8192) >> 14);
        case (ph[31:30])
            2'd0: begin s = sv;  c = cv;  end
            2'd1: begin s = cv;  c = -sv; end
            2'd2: begin s = -sv; c = -cv; end
            default: begin s = -cv; c = sv; end
        endcase
    endfunction

    function automatic longint round_mul(longint a, longint b);
        return (a * b + 64'sd32768) >>> 16;
    endfunction

    function automatic longint unit_sqrt(longint unsigned u);
        longint unsigned v, res, bitv;
        v = u << 16;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic logic signed [26:0] clamp27(longint v);
        if (v > 64'sd67108863) v = 64'sd67108863;
        if (v < -64'sd67108864) v = -64'sd67108864;
        return v[26:0];
    endfunction

    function automatic void polar_point(longint r, logic [31:0] pol, logic [31:0] az,
                                        output longint x, output longint y,
                                        output longint z);
        longint sp, cp, st, ct, rs;
        phase_sin_cos(pol, sp, cp);
        phase_sin_cos(az, st, ct);
        rs = round_mul(r, sp);
        x = round_mul(rs, ct);
        y = round_mul(r, cp);
        z = round_mul(rs, st);
    endfunction

    function automatic seps_pkg::t_xyz sample_offset(longint unsigned a,
                                                     longint unsigned b,
                                                     longint unsigned c);
        longint x, y, z, s, co, r, ms, mc, rad;
        longint bx, by, bz;
        seps_pkg::t_xyz o;
        x = 0; y = 0; z = 0;
        bx = box_q[15:0]; by = box_q[31:16]; bz = box_q[47:32];
        case (shape_q)
            seps_pkg::SHAPE_SPHERE, seps_pkg::SHAPE_HEMI: begin
                r = (emit_q == seps_pkg::EMIT_SHELL) ? longint'(radius_q)
                                                     : longint'((c * radius_q) >> 16);
                polar_point(r, (shape_q == seps_pkg::SHAPE_SPHERE) ? 32'(b << 15)
                                                                    : 32'(b << 14),
                            32'(a << 16), x, y, z);
            end
            seps_pkg::SHAPE_CONE:
                polar_point(longint'((c * length_q) >> 16), 32'(a * sweep_q),
                            32'(b << 16), x, y, z);
            seps_pkg::SHAPE_BOX: begin
                if (emit_q == seps_pkg::EMIT_VOLUME) begin
                    x = ((longint'(a) - 32768) * bx) >>> 8;
                    y = ((longint'(b) - 32768) * by) >>> 8;
                    z = ((longint'(c) - 32768) * bz) >>> 8;
                end else begin
                    // face center, two faces per axis
                    case ((a * seps_pkg::BOX_FACES) >> 16)
                        0: x = bx << 7;
                        1: x = -(bx << 7);
                        2: y = by << 7;
                        3: y = -(by << 7);
                        4: z = bz << 7;
                        default: z = -(bz << 7);
                    endcase
                end
            end
            seps_pkg::SHAPE_CIRCLE: begin
                r = (emit_q == seps_pkg::EMIT_EDGE) ? longint'(radius_q)
                                                    : longint'((b * radius_q) >> 16);
                phase_sin_cos(32'(a * sweep_q), s, co);
                x = round_mul(r, co);
                z = round_mul(r, s);
            end
            seps_pkg::SHAPE_EDGE: x = longint'(a) - 32768;
            seps_pkg::SHAPE_CYLINDER: begin
                r = (emit_q == seps_pkg::EMIT_VOLUME) ?
                    round_mul(unit_sqrt(b), longint'(radius_q)) : longint'(radius_q);
                phase_sin_cos(32'(a << 16), s, co);
                x = round_mul(r, co);
                z = round_mul(r, s);
                y = ((longint'(c) - 32768) * longint'(length_q)) >>> 16;
            end
            seps_pkg::SHAPE_TORUS: begin
                r = (emit_q == seps_pkg::EMIT_VOLUME) ?
                    round_mul(unit_sqrt(c), longint'(radius_q)) : longint'(radius_q);
                phase_sin_cos(32'(b << 16), ms, mc);
                rad = longint'(major_q) + round_mul(r, mc);
                phase_sin_cos(32'(a << 16), s, co);
                x = round_mul(rad, co);
                y = round_mul(r, ms);
                z = round_mul(rad, s);
            end
            default: ;
        endcase
        o.x = clamp27(x);
        o.y = clamp27(y);
        o.z = clamp27(z);
        return o;
    endfunction

    // ---------------- output side ----------------
    always @(posedge i_clk) begin
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(3, 0) != 0);
            default: m_axis_tready <= ($urandom_range(7, 0) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        seps_pkg::t_xyz got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[80:0];
            if (offset_queue.size() == 0) begin
                $error("output word with nothing expected: %h", m_axis_tdata);
                fail_cnt++;
            end else begin
                want = offset_queue.pop_front();
                if (got.x !== want.x) begin
                    $error("offset_x exp %0d got %0d", want.x, got.x);
                    fail_cnt++;
                end
                if (got.y !== want.y) begin
                    $error("offset_y exp %0d got %0d", want.y, got.y);
                    fail_cnt++;
                end
                if (got.z !== want.z) begin
                    $error("offset_z exp %0d got %0d", want.z, got.z);
                    fail_cnt++;
                end
            end
        end
    end

    // ---------------- input side ----------------
    task automatic send_word(input logic [15:0] a, input logic [15:0] b,
                             input logic [15:0] c);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c, b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        offset_queue.push_back(sample_offset(a, b, c));
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
            burst_left = ($urandom_range(3, 0) == 0) ? 40 : $urandom_range(8, 0);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain;
        if (s_axis_tvalid) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        while (offset_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [47:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            seps_pkg::CFG_SHAPE_TYPE:  shape_q  = val[3:0];
            seps_pkg::CFG_EMIT_FROM:   emit_q   = val[1:0];
            seps_pkg::CFG_RADIUS:      radius_q = val[23:0];
            seps_pkg::CFG_SWEEP_ANGLE: sweep_q  = val[16:0];
            seps_pkg::CFG_LENGTH:      length_q = val[23:0];
            seps_pkg::CFG_TORUS_MAJOR: major_q  = val[23:0];
            default:                   box_q    = val;
        endcase
    endtask

    function automatic logic [15:0] rand_frac();
        case ($urandom_range(9, 0))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [47:0] rand_field(int w);
        logic [47:0] v;
        v = 48'({$urandom(), $urandom()});
        case ($urandom_range(5, 0))
            0: return '0;
            1: return (48'd1 << w) - 1;
            2: return v & ((48'd1 << (w > 20 ? 20 : w)) - 1);
            default: return v & ((48'd1 << w) - 1);
        endcase
    endfunction

    // ---------------- tests ----------------
    task automatic test_reset_defaults;
        stall_mode = 0;
        send_word(16'h0000, 16'h0000, 16'h0000);
        send_word(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(16'h8000, 16'h4000, 16'h8000);
        drain();
    endtask

    task automatic test_each_shape;
        stall_mode = 1;
        // every shape code plus two unknown codes (8 and 15), cycling through emit codes
        for (int s = 0; s <= 9; s++) begin
            cfg_write(seps_pkg::CFG_SHAPE_TYPE, (s == 9) ? 48'hF : 48'(s));
            cfg_write(seps_pkg::CFG_EMIT_FROM, 48'(s % 4));
            send_word(16'h0000, 16'hFFFF, 16'h0000);
            send_word(16'hFFFF, 16'h0000, 16'hFFFF);
            drain();
        end
    endtask

    task automatic test_box_faces;
        cfg_write(seps_pkg::CFG_SHAPE_TYPE, 48'(seps_pkg::SHAPE_BOX));
        cfg_write(seps_pkg::CFG_EMIT_FROM, 48'(seps_pkg::EMIT_SHELL));
        cfg_write(seps_pkg::CFG_BOX_SIZE, 48'hFFFF_8000_0001);
        for (int f = 0; f < seps_pkg::BOX_FACES; f++)
            send_word(16'((f * 65536 + 65535) / seps_pkg::BOX_FACES), 16'h1234, 16'h4321);
        drain();
    endtask

    task automatic test_random_phases;
        for (int p = 0; p < 11; p++) begin
            stall_mode = p % 3;
            if (p == 0) begin
                cfg_write(seps_pkg::CFG_RADIUS, 48'hFFFFFF);
                cfg_write(seps_pkg::CFG_SWEEP_ANGLE, 48'h1FFFF);
                cfg_write(seps_pkg::CFG_LENGTH, 48'hFFFFFF);
                cfg_write(seps_pkg::CFG_TORUS_MAJOR, 48'hFFFFFF);
                cfg_write(seps_pkg::CFG_BOX_SIZE, 48'hFFFF_FFFF_FFFF);
            end else if (p == 1) begin
                cfg_write(seps_pkg::CFG_RADIUS, '0);
                cfg_write(seps_pkg::CFG_SWEEP_ANGLE, '0);
                cfg_write(seps_pkg::CFG_LENGTH, '0);
                cfg_write(seps_pkg::CFG_TORUS_MAJOR, '0);
                cfg_write(seps_pkg::CFG_BOX_SIZE, '0);
            end else begin
                cfg_write(seps_pkg::CFG_RADIUS, rand_field(24));
                cfg_write(seps_pkg::CFG_SWEEP_ANGLE, ($urandom_range(1, 0) != 0) ?
                          48'($urandom_range(65536, 0)) : rand_field(17));
                cfg_write(seps_pkg::CFG_LENGTH, rand_field(24));
                cfg_write(seps_pkg::CFG_TORUS_MAJOR, rand_field(24));
                cfg_write(seps_pkg::CFG_BOX_SIZE, rand_field(48));
            end
            cfg_write(seps_pkg::CFG_EMIT_FROM, 48'($urandom_range(3, 0)));
            cfg_write(seps_pkg::CFG_SHAPE_TYPE, ($urandom_range(7, 0) == 0) ?
                      48'($urandom_range(15, 0)) : 48'($urandom_range(7, 0)));
            for (int n = 0; n < 50; n++) begin
                // sprinkle shape and emit changes only at idle points of each phase
                if (n == 25) begin
                    drain();
                    cfg_write(seps_pkg::CFG_SHAPE_TYPE, 48'((shape_q + 1) % 9));
                    cfg_write(seps_pkg::CFG_EMIT_FROM, 48'($urandom_range(3, 0)));
                end
                send_word(rand_frac(), rand_frac(), rand_frac());
            end
            drain();
        end
    endtask

    initial begin
        shape_q = seps_pkg::SHAPE_SPHERE; emit_q = seps_pkg::EMIT_VOLUME;
        radius_q = 24'd65536; sweep_q = 17'd65536; length_q = 24'd65536;
        major_q = 24'd65536; box_q = 48'd1099528405248;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_each_shape();
        test_box_faces();
        test_random_phases();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_cnt == 0 && offset_queue.size() == 0)
            $display("shape_emission_point_sampler_core verification clean");
        else
            $display("shape_emission_point_sampler_core verification failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("shape_emission_point_sampler_core verification failed");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/seps_pkg.sv
hw/rtl/seps_sincos.sv
hw/rtl/seps_sqrt.sv
hw/rtl/shape_emission_point_sampler_core.sv
verif/shape_emission_point_sampler_core_tb.sv
